>>> sv/cfa_enc_pkg.sv
// Shared types and constants for the call frame instruction encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cfa_enc_pkg;

    // Register numbers at or above this limit are rejected.
    localparam logic [63:0] REG_LIMIT = 64'd188;

    // Depth of the queue between the classifier and the byte sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDE_MODE      = 2'd0;
    localparam logic [1:0] CFG_ADDS_CLOSED    = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN_OUT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_OPCODE = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    // Call frame opcodes.
    localparam logic [7:0] OP_NOP              = 8'h00;
    localparam logic [7:0] OP_SET_LOC          = 8'h01;
    localparam logic [7:0] OP_ADVANCE_LOC1     = 8'h02;
    localparam logic [7:0] OP_ADVANCE_LOC2     = 8'h03;
    localparam logic [7:0] OP_ADVANCE_LOC4     = 8'h04;
    localparam logic [7:0] OP_OFFSET_EXTENDED  = 8'h05;
    localparam logic [7:0] OP_RESTORE_EXTENDED = 8'h06;
    localparam logic [7:0] OP_UNDEFINED        = 8'h07;
    localparam logic [7:0] OP_SAME_VALUE       = 8'h08;
    localparam logic [7:0] OP_REGISTER         = 8'h09;
    localparam logic [7:0] OP_REMEMBER_STATE   = 8'h0a;
    localparam logic [7:0] OP_RESTORE_STATE    = 8'h0b;
    localparam logic [7:0] OP_DEF_CFA          = 8'h0c;
    localparam logic [7:0] OP_DEF_CFA_REGISTER = 8'h0d;
    localparam logic [7:0] OP_DEF_CFA_OFFSET   = 8'h0e;
    localparam logic [7:0] OP_ADVANCE_LOC      = 8'h40;
    localparam logic [7:0] OP_OFFSET           = 8'h80;
    localparam logic [7:0] OP_RESTORE          = 8'hc0;

    // Configuration as seen by the classifier.
    typedef struct packed {
        logic wide_mode;
        logic adds_closed;
        logic big_endian_out;
    } cfa_enc_cfg_t;

    // One classified instruction: a head byte, an optional fixed-width field
    // (already in emission order, low byte first), then up to two LEB128 fields.
    typedef struct packed {
        logic        err;
        logic [1:0]  status;
        logic [7:0]  head;
        logic        fix_en;
        logic [3:0]  fix_len;
        logic        uleb_a;
        logic        uleb_b;
        logic [63:0] val_a;
        logic [63:0] val_b;
    } cfa_enc_desc_t;

endpackage

`default_nettype wire

>>> sv/cfa_enc_if.sv
// Channel interfaces of the call frame instruction encoder: instruction input,
// encoded byte output and configuration writes. No dependencies.
`default_nettype none

interface cfa_enc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  action;
    logic [63:0] first_operand;
    logic [63:0] second_operand;

    modport source (output valid, output action, output first_operand,
                    output second_operand, input ready);
    modport sink (input valid, input action, input first_operand,
                  input second_operand, output ready);
endinterface

interface cfa_enc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [31:0] byte_position;
    logic        last_byte;
    logic [1:0]  status;

    modport source (output valid, output out_byte, output byte_valid,
                    output byte_position, output last_byte, output status,
                    input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input byte_position, input last_byte, input status,
                  output ready);
endinterface

interface cfa_enc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/cfa_instruction_encoder.sv
// Top level of the call frame instruction encoder: configuration registers and
// the classifier, queue and byte sequencer. Depends on cfa_enc_pkg, cfa_enc_if.
//
//   Channel  Dir  Carries
//   instr    in   action, first_operand, second_operand (valid/ready)
//   enc      out  out_byte, byte_valid, byte_position, last_byte, status
//   cfg      in   index, data register writes (always ready)
//
// An instruction yields the head byte and then its field bytes, emitted by the
// byte sequencer one byte a cycle while the output is not stalled; the next
// instruction leaves the queue as the last byte of the one before is emitted.
// A two-entry queue lets instructions transfer while earlier ones are emitted.
// Reset clears the configuration and the running byte offset.
// A stalled output holds its result; the sequencer and queue then stall in turn.
`default_nettype none

module cfa_instruction_encoder (
    input  logic         clk,
    input  logic         rst_n,
    cfa_enc_in_if.sink   instr,
    cfa_enc_out_if.source enc,
    cfa_enc_cfg_if.sink  cfg
);
    import cfa_enc_pkg::*;

    cfa_enc_cfg_t  cfg_reg;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    cfa_enc_desc_t push_desc;
    cfa_enc_desc_t head_desc;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WIDE_MODE:      cfg_reg.wide_mode      <= cfg.data;
                CFG_ADDS_CLOSED:    cfg_reg.adds_closed    <= cfg.data;
                CFG_BIG_ENDIAN_OUT: cfg_reg.big_endian_out <= cfg.data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    cfa_enc_front u_front (
        .instr  (instr),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_desc (push_desc)
    );

    cfa_enc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    cfa_enc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_desc  (head_desc),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .enc     (enc)
    );

endmodule

`default_nettype wire

>>> sv/cfa_enc_front.sv
// Front end: accepts instructions, checks ranges and opcode, and builds a
// descriptor for the byte sequencer. Depends on cfa_enc_pkg and cfa_enc_in_if.
`default_nettype none

module cfa_enc_front (
    cfa_enc_in_if.sink                  instr,
    input  cfa_enc_pkg::cfa_enc_cfg_t   cfg,
    input  logic                        q_full,
    output logic                        q_push,
    output cfa_enc_pkg::cfa_enc_desc_t  q_desc
);
    import cfa_enc_pkg::*;

    // Put the low len bytes in big endian emission order when asked.
    function automatic logic [63:0] order_bytes(input logic [63:0] v,
                                                input logic [3:0] len,
                                                input logic big);
        logic [63:0] r;
        r = v;
        if (big)
        begin
            unique case (len)
                4'd2:
                begin
                    for (int i = 0; i < 2; i++)
                        r[8*i +: 8] = v[8*(1-i) +: 8];
                end
                4'd4:
                begin
                    for (int i = 0; i < 4; i++)
                        r[8*i +: 8] = v[8*(3-i) +: 8];
                end
                4'd8:
                begin
                    for (int i = 0; i < 8; i++)
                        r[8*i +: 8] = v[8*(7-i) +: 8];
                end
                default: r = v;
            endcase
        end
        return r;
    endfunction

    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] delta_a;
    logic [63:0] scaled_a;
    logic [63:0] scaled_b;
    logic        a_bad;
    logic        b_bad;
    cfa_enc_desc_t d;

    assign a        = instr.first_operand;
    assign b        = instr.second_operand;
    assign delta_a  = {2'b00, a[63:2]};
    assign scaled_a = cfg.wide_mode ? {2'b00, a[63:2]} : {32'd0, a[33:2]};
    assign scaled_b = cfg.wide_mode ? {2'b00, b[63:2]} : {32'd0, b[33:2]};
    assign a_bad    = (a >= REG_LIMIT);
    assign b_bad    = (b >= REG_LIMIT);

    // Classify the opcode and lay out the fields that follow the head byte.
    always_comb
    begin
        d         = '0;
        d.status  = ST_OK;
        d.head    = instr.action;
        if (cfg.adds_closed)
        begin
            d.err    = 1'b1;
            d.status = ST_CLOSED;
        end
        else
        begin
            unique case (instr.action)
                OP_ADVANCE_LOC:
                begin
                    if (|a[63:8])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.head = OP_ADVANCE_LOC | {2'b00, a[7:2]};
                end
                OP_OFFSET:
                begin
                    if (|a[63:6])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.head   = OP_OFFSET | {2'b00, a[5:0]};
                    d.uleb_a = 1'b1;
                    d.val_a  = scaled_b;
                end
                OP_RESTORE:
                begin
                    if (|a[63:6])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.head = OP_RESTORE | {2'b00, a[5:0]};
                end
                OP_SET_LOC:
                begin
                    d.fix_en = 1'b1;
                    if (cfg.wide_mode)
                    begin
                        d.fix_len = 4'd8;
                        d.val_a   = order_bytes(a, 4'd8, cfg.big_endian_out);
                    end
                    else
                    begin
                        d.fix_len = 4'd4;
                        d.val_a   = order_bytes(a, 4'd4, cfg.big_endian_out);
                    end
                end
                OP_ADVANCE_LOC1:
                begin
                    if (|a[63:10])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.fix_en  = 1'b1;
                    d.fix_len = 4'd1;
                    d.val_a   = delta_a;
                end
                OP_ADVANCE_LOC2:
                begin
                    if (|a[63:18])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.fix_en  = 1'b1;
                    d.fix_len = 4'd2;
                    d.val_a   = order_bytes(delta_a, 4'd2, cfg.big_endian_out);
                end
                OP_ADVANCE_LOC4:
                begin
                    if (|a[63:34])
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.fix_en  = 1'b1;
                    d.fix_len = 4'd4;
                    d.val_a   = order_bytes(delta_a, 4'd4, cfg.big_endian_out);
                end
                OP_OFFSET_EXTENDED, OP_DEF_CFA:
                begin
                    if (a_bad)
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.uleb_a = 1'b1;
                    d.val_a  = a;
                    d.uleb_b = 1'b1;
                    d.val_b  = scaled_b;
                end
                OP_RESTORE_EXTENDED, OP_UNDEFINED, OP_SAME_VALUE, OP_DEF_CFA_REGISTER:
                begin
                    if (a_bad)
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.uleb_a = 1'b1;
                    d.val_a  = a;
                end
                OP_REGISTER:
                begin
                    if (a_bad || b_bad)
                    begin
                        d.err    = 1'b1;
                        d.status = ST_RANGE;
                    end
                    d.uleb_a = 1'b1;
                    d.val_a  = a;
                    d.uleb_b = 1'b1;
                    d.val_b  = b;
                end
                OP_REMEMBER_STATE, OP_RESTORE_STATE, OP_NOP:
                begin
                    d.head = instr.action;
                end
                OP_DEF_CFA_OFFSET:
                begin
                    d.uleb_a = 1'b1;
                    d.val_a  = scaled_a;
                end
                default:
                begin
                    d.err    = 1'b1;
                    d.status = ST_OPCODE;
                end
            endcase
        end
    end

    // An instruction transfers whenever the queue has room.
    assign instr.ready = !q_full;
    assign q_push      = instr.valid && !q_full;
    assign q_desc      = d;

endmodule

`default_nettype wire

>>> sv/cfa_enc_queue.sv
// Short descriptor queue between the classifier and the byte sequencer.
// Depends on cfa_enc_pkg.
`default_nettype none

module cfa_enc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  cfa_enc_pkg::cfa_enc_desc_t  push_desc,
    input  logic                        pop,
    output cfa_enc_pkg::cfa_enc_desc_t  head_desc,
    output logic                        full,
    output logic                        empty
);
    import cfa_enc_pkg::*;

    cfa_enc_desc_t     mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/cfa_enc_back.sv
// Back end: walks one descriptor a byte per cycle unless the output stalls, emits LEB128
// and fixed fields, and numbers the bytes. Depends on cfa_enc_pkg and cfa_enc_out_if.
`default_nettype none

module cfa_enc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfa_enc_pkg::cfa_enc_desc_t  q_desc,
    input  logic                        q_empty,
    output logic                        q_pop,
    cfa_enc_out_if.source               enc
);
    import cfa_enc_pkg::*;

    typedef enum logic [1:0] {PH_HEAD, PH_FIX, PH_ULEB_A, PH_ULEB_B} phase_t;

    phase_t        phase_reg;
    logic          busy_reg;
    cfa_enc_desc_t desc_reg;
    logic [63:0]   sh_reg;
    logic [3:0]    cnt_reg;
    logic [31:0]   offset_reg;
    logic          ov_reg;
    logic [7:0]    obyte_reg;
    logic          obv_reg;
    logic [31:0]   opos_reg;
    logic          olast_reg;
    logic [1:0]    ost_reg;

    phase_t        phase_next;
    logic [63:0]   sh_next;
    logic [3:0]    cnt_next;
    logic [7:0]    byte_now;
    logic          data_now;
    logic          last_now;
    logic          more;
    logic          step;
    logic          finish;

    assign more   = |sh_reg[63:7];
    assign step   = busy_reg && (!ov_reg || enc.ready);
    assign finish = step && last_now;
    assign q_pop  = !q_empty && (!busy_reg || finish);

    // Byte of the current phase and where the walk goes next.
    always_comb
    begin
        phase_next = phase_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        byte_now   = 8'd0;
        data_now   = 1'b1;
        last_now   = 1'b0;
        unique case (phase_reg)
            PH_HEAD:
            begin
                byte_now = desc_reg.err ? 8'd0 : desc_reg.head;
                data_now = !desc_reg.err;
                last_now = desc_reg.err ||
                           (!desc_reg.fix_en && !desc_reg.uleb_a && !desc_reg.uleb_b);
                if (desc_reg.fix_en)
                begin
                    phase_next = PH_FIX;
                    sh_next    = desc_reg.val_a;
                    cnt_next   = desc_reg.fix_len;
                end
                else if (desc_reg.uleb_a)
                begin
                    phase_next = PH_ULEB_A;
                    sh_next    = desc_reg.val_a;
                end
                else
                begin
                    phase_next = PH_ULEB_B;
                    sh_next    = desc_reg.val_b;
                end
            end
            PH_FIX:
            begin
                byte_now = sh_reg[7:0];
                last_now = (cnt_reg == 4'd1);
                sh_next  = {8'd0, sh_reg[63:8]};
                cnt_next = cnt_reg - 4'd1;
            end
            PH_ULEB_A:
            begin
                byte_now = {more, sh_reg[6:0]};
                last_now = !more && !desc_reg.uleb_b;
                sh_next  = {7'd0, sh_reg[63:7]};
                if (!more)
                begin
                    phase_next = PH_ULEB_B;
                    sh_next    = desc_reg.val_b;
                end
            end
            PH_ULEB_B:
            begin
                byte_now = {more, sh_reg[6:0]};
                last_now = !more;
                sh_next  = {7'd0, sh_reg[63:7]};
            end
            default:
            begin
                byte_now = 8'd0;
            end
        endcase
    end

    // Sequencer state, running offset and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            busy_reg   <= 1'b0;
            desc_reg   <= '0;
            sh_reg     <= '0;
            cnt_reg    <= '0;
            offset_reg <= '0;
            ov_reg     <= 1'b0;
            obyte_reg  <= '0;
            obv_reg    <= 1'b0;
            opos_reg   <= '0;
            olast_reg  <= 1'b0;
            ost_reg    <= ST_OK;
        end
        else
        begin
            if (q_pop)
            begin
                desc_reg  <= q_desc;
                phase_reg <= PH_HEAD;
                busy_reg  <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (step)
            begin
                phase_reg <= phase_next;
                sh_reg    <= sh_next;
                cnt_reg   <= cnt_next;
            end

            if (step)
            begin
                ov_reg    <= 1'b1;
                obyte_reg <= byte_now;
                obv_reg   <= data_now;
                opos_reg  <= offset_reg;
                olast_reg <= last_now;
                ost_reg   <= desc_reg.status;
                if (data_now)
                    offset_reg <= offset_reg + 32'd1;
            end
            else if (enc.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign enc.valid         = ov_reg;
    assign enc.out_byte      = obyte_reg;
    assign enc.byte_valid    = obv_reg;
    assign enc.byte_position = opos_reg;
    assign enc.last_byte     = olast_reg;
    assign enc.status        = ost_reg;

endmodule

`default_nettype wire
